/* rtl/epcd_pkg.sv */
package epcd_pkg;

   localparam int unsigned EPOCH_W  = 32;
   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;
   localparam int unsigned DAYS_W   = 16;
   localparam int unsigned SECS_W   = 17;
   localparam int unsigned DOY_W    = 9;
   localparam int unsigned DBLK_W   = 11;
   localparam int unsigned BLK_W    = 6;

   localparam logic [EPOCH_W-1:0] BASE_OFFSET = 32'd63072000;
   localparam logic [YEAR_W-1:0]  BASE_YEAR   = 12'd1972;

   // seconds per day = 128 * 675
   localparam logic [9:0]  DAY_ODD     = 10'd675;
   localparam logic [25:0] DAY_RECIP   = 26'd50903316;   // floor(2^35 / 675)
   localparam int unsigned DAY_SHIFT   = 35;

   localparam logic [10:0] BLK_DAYS    = 11'd1461;
   localparam logic [16:0] BLK_RECIP   = 17'd91867;      // floor(2^27 / 1461)
   localparam int unsigned BLK_SHIFT   = 27;

   // seconds per hour = 16 * 225
   localparam logic [7:0]  HOUR_ODD    = 8'd225;
   localparam logic [13:0] HOUR_RECIP  = 14'd9320;       // floor(2^21 / 225)
   localparam int unsigned HOUR_SHIFT  = 21;

   // seconds per minute = 4 * 15
   localparam logic [3:0]  MIN_ODD     = 4'd15;
   localparam logic [10:0] MIN_RECIP   = 11'd1092;       // floor(2^14 / 15)
   localparam int unsigned MIN_SHIFT   = 14;

   localparam logic [DBLK_W-1:0] LEAP_YEAR_DAYS   = 11'd366;
   localparam logic [DBLK_W-1:0] COMMON_YEAR_DAYS = 11'd365;
   localparam logic [DBLK_W-1:0] TWO_YEAR_DAYS    = 11'd730;

   localparam logic [DOY_W-1:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   function automatic logic [DOY_W-1:0] month_start(input logic [3:0] idx, input logic leap);
      logic [DOY_W-1:0] base;
      base = MONTH_START[idx];
      if (leap && (idx >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

/* rtl/epcd_if.sv */
interface epcd_req_if import epcd_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [EPOCH_W-1:0]   epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface epcd_mid_if import epcd_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 valid_res;
   logic [DAYS_W-1:0]    days;
   logic [SECS_W-1:0]    secs;

   modport source (output valid, output valid_res, output days, output secs, input ready);
   modport sink   (input valid, input valid_res, input days, input secs, output ready);
endinterface

interface epcd_rsp_if import epcd_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 valid_res;
   logic [YEAR_W-1:0]    year;
   logic [MONTH_W-1:0]   month;
   logic [DAY_W-1:0]     day_of_month;
   logic [HOUR_W-1:0]    hour;
   logic [MINUTE_W-1:0]  minute;
   logic [SECOND_W-1:0]  second;

   modport source (output valid, output valid_res, output year, output month,
                   output day_of_month, output hour, output minute, output second,
                   input ready);
   modport sink   (input valid, input valid_res, input year, input month,
                   input day_of_month, input hour, input minute, input second,
                   output ready);
endinterface

/* rtl/epcd_day_split.sv */
module epcd_day_split import epcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   epcd_req_if.sink      req_ch,
   epcd_mid_if.source    mid_ch
);

   logic s1_v_ff, s2_v_ff, s3_v_ff;
   logic en1, en2, en3;

   logic [EPOCH_W-1:0] rest_in;
   logic               vres_in;
   logic               s1_vres_ff, s2_vres_ff, s3_vres_ff;
   logic [24:0]        s1_x_ff, s2_x_ff;
   logic [6:0]         s1_lo_ff, s2_lo_ff;

   logic [50:0]        qprod_in;
   logic [DAYS_W-1:0]  s2_q_ff;

   logic [25:0]        back_in;
   logic [24:0]        rem_raw_in;
   logic [10:0]        rem_in;
   logic [DAYS_W-1:0]  days_in;
   logic [9:0]         rem_fix_in;
   logic [DAYS_W-1:0]  s3_days_ff;
   logic [SECS_W-1:0]  s3_secs_ff;

   assign en3 = !s3_v_ff || mid_ch.ready;
   assign en2 = !s2_v_ff || en3;
   assign en1 = !s1_v_ff || en2;
   assign req_ch.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (en1) s1_v_ff <= req_ch.valid;
         if (en2) s2_v_ff <= s1_v_ff;
         if (en3) s3_v_ff <= s2_v_ff;
      end
   end

   assign vres_in = req_ch.epoch_seconds >= BASE_OFFSET;
   assign rest_in = req_ch.epoch_seconds - BASE_OFFSET;

   assign qprod_in = 51'(s1_x_ff) * 51'(DAY_RECIP);

   assign back_in    = 26'(s2_q_ff) * 26'(DAY_ODD);
   assign rem_raw_in = s2_x_ff - back_in[24:0];
   assign rem_in     = rem_raw_in[10:0];

   always_comb begin
      if (rem_in >= 11'(DAY_ODD)) begin
         days_in    = s2_q_ff + 16'd1;
         rem_fix_in = 10'(rem_in - 11'(DAY_ODD));
      end else begin
         days_in    = s2_q_ff;
         rem_fix_in = rem_in[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_vres_ff <= vres_in;
         s1_x_ff    <= rest_in[31:7];
         s1_lo_ff   <= rest_in[6:0];
      end
      if (en2) begin
         s2_vres_ff <= s1_vres_ff;
         s2_x_ff    <= s1_x_ff;
         s2_lo_ff   <= s1_lo_ff;
         s2_q_ff    <= qprod_in[50:DAY_SHIFT];
      end
      if (en3) begin
         s3_vres_ff <= s2_vres_ff;
         s3_days_ff <= days_in;
         s3_secs_ff <= {rem_fix_in, s2_lo_ff};
      end
   end

   assign mid_ch.valid     = s3_v_ff;
   assign mid_ch.valid_res = s3_vres_ff;
   assign mid_ch.days      = s3_days_ff;
   assign mid_ch.secs      = s3_secs_ff;

endmodule

/* rtl/epcd_cal_split.sv */
module epcd_cal_split import epcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   epcd_mid_if.sink      mid_ch,
   epcd_rsp_if.source    rsp_ch
);

   logic s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic en4, en5, en6, en7;

   // stage 4: reciprocal products
   logic [32:0]        bprod_in;
   logic [26:0]        hprod_in;
   logic               s4_vres_ff;
   logic [DAYS_W-1:0]  s4_days_ff;
   logic [SECS_W-1:0]  s4_secs_ff;
   logic [BLK_W-1:0]   s4_qb_ff;
   logic [5:0]         s4_qh_ff;

   // stage 5: remainders
   logic [16:0]        bback_in;
   logic [DAYS_W-1:0]  brem_raw_in;
   logic [11:0]        brem_in;
   logic [BLK_W-1:0]   blocks_in;
   logic [DBLK_W-1:0]  dday_in;
   logic [13:0]        hback_in;
   logic [12:0]        hrem_raw_in;
   logic [8:0]         hrem_in;
   logic [HOUR_W-1:0]  hour_in;
   logic [7:0]         hrem_fix_in;
   logic               s5_vres_ff;
   logic [BLK_W-1:0]   s5_blocks_ff;
   logic [DBLK_W-1:0]  s5_dday_ff;
   logic [HOUR_W-1:0]  s5_hour_ff;
   logic [11:0]        s5_rsec_ff;

   // stage 6: year split, minute product
   logic               leap_in;
   logic [DBLK_W-1:0]  d2_in;
   logic [1:0]         yoff_in;
   logic [DBLK_W-1:0]  doy_in;
   logic [20:0]        mprod_in;
   logic               s6_vres_ff;
   logic [YEAR_W-1:0]  s6_year_ff;
   logic               s6_leap_ff;
   logic [DOY_W-1:0]   s6_doy_ff;
   logic [5:0]         s6_qm_ff;
   logic [HOUR_W-1:0]  s6_hour_ff;
   logic [11:0]        s6_rsec_ff;

   // stage 7: month walk, minute and second
   logic [MONTH_W-1:0]  month_in;
   logic [DOY_W-1:0]    mstart_in;
   logic [DOY_W-1:0]    dom_in;
   logic [9:0]          mback_in;
   logic [9:0]          mrem_in;
   logic [MINUTE_W-1:0] minute_in;
   logic [3:0]          mrem_fix_in;
   logic                s7_vres_ff;
   logic [YEAR_W-1:0]   s7_year_ff;
   logic [MONTH_W-1:0]  s7_month_ff;
   logic [DAY_W-1:0]    s7_dom_ff;
   logic [HOUR_W-1:0]   s7_hour_ff;
   logic [MINUTE_W-1:0] s7_minute_ff;
   logic [SECOND_W-1:0] s7_second_ff;

   assign en7 = !s7_v_ff || rsp_ch.ready;
   assign en6 = !s6_v_ff || en7;
   assign en5 = !s5_v_ff || en6;
   assign en4 = !s4_v_ff || en5;
   assign mid_ch.ready = en4;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else begin
         if (en4) s4_v_ff <= mid_ch.valid;
         if (en5) s5_v_ff <= s4_v_ff;
         if (en6) s6_v_ff <= s5_v_ff;
         if (en7) s7_v_ff <= s6_v_ff;
      end
   end

   assign bprod_in = 33'(mid_ch.days) * 33'(BLK_RECIP);
   assign hprod_in = 27'(mid_ch.secs[16:4]) * 27'(HOUR_RECIP);

   assign bback_in    = 17'(s4_qb_ff) * 17'(BLK_DAYS);
   assign brem_raw_in = s4_days_ff - bback_in[15:0];
   assign brem_in     = brem_raw_in[11:0];
   assign hback_in    = 14'(s4_qh_ff) * 14'(HOUR_ODD);
   assign hrem_raw_in = s4_secs_ff[16:4] - hback_in[12:0];
   assign hrem_in     = hrem_raw_in[8:0];

   always_comb begin
      if (brem_in >= 12'(BLK_DAYS)) begin
         blocks_in = s4_qb_ff + 6'd1;
         dday_in   = 11'(brem_in - 12'(BLK_DAYS));
      end else begin
         blocks_in = s4_qb_ff;
         dday_in   = brem_in[10:0];
      end
      if (hrem_in >= 9'(HOUR_ODD)) begin
         hour_in     = 5'(s4_qh_ff + 6'd1);
         hrem_fix_in = 8'(hrem_in - 9'(HOUR_ODD));
      end else begin
         hour_in     = s4_qh_ff[4:0];
         hrem_fix_in = hrem_in[7:0];
      end
   end

   assign leap_in  = s5_dday_ff < LEAP_YEAR_DAYS;
   assign d2_in    = s5_dday_ff - LEAP_YEAR_DAYS;
   assign mprod_in = 21'(s5_rsec_ff[11:2]) * 21'(MIN_RECIP);

   always_comb begin
      if (leap_in) begin
         yoff_in = 2'd0;
         doy_in  = s5_dday_ff;
      end else if (d2_in < COMMON_YEAR_DAYS) begin
         yoff_in = 2'd1;
         doy_in  = d2_in;
      end else if (d2_in < TWO_YEAR_DAYS) begin
         yoff_in = 2'd2;
         doy_in  = d2_in - COMMON_YEAR_DAYS;
      end else begin
         yoff_in = 2'd3;
         doy_in  = d2_in - TWO_YEAR_DAYS;
      end
   end

   always_comb begin
      month_in  = 4'd1;
      mstart_in = '0;
      for (int i = 1; i < 12; i++) begin
         if (s6_doy_ff >= month_start(4'(i), s6_leap_ff)) begin
            month_in  = 4'(i + 1);
            mstart_in = month_start(4'(i), s6_leap_ff);
         end
      end
      dom_in = s6_doy_ff - mstart_in + 9'd1;
   end

   assign mback_in = 10'(s6_qm_ff) * 10'(MIN_ODD);
   assign mrem_in  = s6_rsec_ff[11:2] - mback_in;

   always_comb begin
      if (mrem_in >= 10'(MIN_ODD)) begin
         minute_in   = s6_qm_ff + 6'd1;
         mrem_fix_in = 4'(mrem_in - 10'(MIN_ODD));
      end else begin
         minute_in   = s6_qm_ff;
         mrem_fix_in = mrem_in[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_vres_ff <= mid_ch.valid_res;
         s4_days_ff <= mid_ch.days;
         s4_secs_ff <= mid_ch.secs;
         s4_qb_ff   <= bprod_in[32:BLK_SHIFT];
         s4_qh_ff   <= hprod_in[26:HOUR_SHIFT];
      end
      if (en5) begin
         s5_vres_ff   <= s4_vres_ff;
         s5_blocks_ff <= blocks_in;
         s5_dday_ff   <= dday_in;
         s5_hour_ff   <= hour_in;
         s5_rsec_ff   <= {hrem_fix_in, s4_secs_ff[3:0]};
      end
      if (en6) begin
         s6_vres_ff <= s5_vres_ff;
         s6_year_ff <= BASE_YEAR + {4'd0, s5_blocks_ff, 2'b00} + 12'(yoff_in);
         s6_leap_ff <= leap_in;
         s6_doy_ff  <= doy_in[8:0];
         s6_qm_ff   <= mprod_in[19:MIN_SHIFT];
         s6_hour_ff <= s5_hour_ff;
         s6_rsec_ff <= s5_rsec_ff;
      end
      if (en7) begin
         s7_vres_ff <= s6_vres_ff;
         if (s6_vres_ff) begin
            s7_year_ff   <= s6_year_ff;
            s7_month_ff  <= month_in;
            s7_dom_ff    <= dom_in[4:0];
            s7_hour_ff   <= s6_hour_ff;
            s7_minute_ff <= minute_in;
            s7_second_ff <= {mrem_fix_in, s6_rsec_ff[1:0]};
         end else begin
            s7_year_ff   <= '0;
            s7_month_ff  <= '0;
            s7_dom_ff    <= '0;
            s7_hour_ff   <= '0;
            s7_minute_ff <= '0;
            s7_second_ff <= '0;
         end
      end
   end

   assign rsp_ch.valid        = s7_v_ff;
   assign rsp_ch.valid_res    = s7_vres_ff;
   assign rsp_ch.year         = s7_year_ff;
   assign rsp_ch.month        = s7_month_ff;
   assign rsp_ch.day_of_month = s7_dom_ff;
   assign rsp_ch.hour         = s7_hour_ff;
   assign rsp_ch.minute       = s7_minute_ff;
   assign rsp_ch.second       = s7_second_ff;

endmodule

/* rtl/epoch_to_calendar_date.sv */
// Converts a 32-bit count of seconds since 1970-01-01 into year, month, day, hour, minute
// and second, counting from 1972 with every fourth year a leap year (exact through
// 2100-02-28); epochs before 1972 return valid_res low and all other fields zero. One
// beat is taken every cycle unless rsp_ch stalls; the pipeline depth comes from the
// chain of constant-reciprocal multiplies (days, four-year blocks, hours, minutes),
// each followed by a register and a one-step remainder correction. Back-pressure on
// rsp_ch stalls the pipeline stage by stage, so bubbles are squeezed out.
module epoch_to_calendar_date import epcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   epcd_req_if.sink      req_ch,
   epcd_rsp_if.source    rsp_ch
);

   epcd_mid_if mid_ch ();

   epcd_day_split u_day_split (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .mid_ch (mid_ch.source)
   );

   epcd_cal_split u_cal_split (
      .clock  (clock),
      .reset  (reset),
      .mid_ch (mid_ch.sink),
      .rsp_ch (rsp_ch)
   );

endmodule

/* test/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import epcd_pkg::*;

   localparam int unsigned SECS_PER_DAY   = 86400;
   localparam int unsigned SECS_PER_HOUR  = 3600;
   localparam int unsigned SECS_PER_MIN   = 60;
   localparam int unsigned DAYS_PER_QUAD  = 1461;
   localparam int unsigned DAYS_IN_LEAP   = 366;
   localparam int unsigned DAYS_IN_COMMON = 365;
   localparam int unsigned LAST_SAFE_DAY  = 48979;
   localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   localparam int RANDOM_BEATS = 500;
   localparam int CALM_BEATS   = 60;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 30;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int NUM_PROBES   = 22;

   typedef struct packed {
      logic                valid_res;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day_of_month;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } calendar_type;

   typedef struct {
      logic [EPOCH_W-1:0] epoch;
      bit                 typed;
      calendar_type       date;
   } probe_type;

   typedef struct {
      logic [EPOCH_W-1:0] epoch;
      calendar_type       date;
   } pending_type;

   localparam calendar_type NO_DATE = '0;

   logic clock = 1'b0;
   logic reset;

   epcd_req_if req_ch ();
   epcd_rsp_if rsp_ch ();

   epoch_to_calendar_date dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   pending_type pending_dates [$];
   int          req_beats;
   int          rsp_beats;
   int          early_epochs;
   int          bad_beats;
   int          cycle_count;
   bit          calm_tail;

   probe_type probes [NUM_PROBES] = '{
      '{32'd0,          1'b1, NO_DATE},
      '{32'd63071999,   1'b1, NO_DATE},
      '{32'd63072000,   1'b1, '{1'b1, 12'd1972, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
      '{32'd63158399,   1'b1, '{1'b1, 12'd1972, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
      '{32'hFFFFFFFF,   1'b0, NO_DATE},
      '{32'd68169600,   1'b0, NO_DATE},
      '{32'd68256000,   1'b0, NO_DATE},
      '{32'd94694399,   1'b0, NO_DATE},
      '{32'd94694400,   1'b0, NO_DATE},
      '{32'd99791999,   1'b0, NO_DATE},
      '{32'd99792000,   1'b0, NO_DATE},
      '{32'd189302399,  1'b0, NO_DATE},
      '{32'd189302400,  1'b0, NO_DATE},
      '{32'd951868799,  1'b0, NO_DATE},
      '{32'd4107542399, 1'b0, NO_DATE},
      '{32'd4107542400, 1'b0, NO_DATE},
      '{32'h7FFFFFFF,   1'b0, NO_DATE},
      '{32'h80000000,   1'b0, NO_DATE},
      '{32'h55555555,   1'b0, NO_DATE},
      '{32'hAAAAAAAA,   1'b0, NO_DATE},
      '{32'd63075599,   1'b0, NO_DATE},
      '{32'd63075600,   1'b0, NO_DATE}
   };

   function automatic calendar_type predict_date(input logic [EPOCH_W-1:0] epoch);
      int unsigned  rest;
      int unsigned  day_count;
      int unsigned  tod;
      int unsigned  quads;
      int unsigned  yr;
      int unsigned  mon;
      int unsigned  len;
      bit           leap_yr;
      calendar_type d;
      d = NO_DATE;
      if (epoch < BASE_OFFSET) begin
         return d;
      end
      rest      = epoch - BASE_OFFSET;
      day_count = rest / SECS_PER_DAY;
      tod       = rest % SECS_PER_DAY;
      quads     = day_count / DAYS_PER_QUAD;
      day_count = day_count % DAYS_PER_QUAD;
      yr        = BASE_YEAR + 4 * quads;
      leap_yr   = (day_count < DAYS_IN_LEAP);
      if (!leap_yr) begin
         day_count = day_count - DAYS_IN_LEAP;
         yr        = yr + 1 + day_count / DAYS_IN_COMMON;
         day_count = day_count % DAYS_IN_COMMON;
      end
      mon = 1;
      for (int m = 0; m < 12; m++) begin
         len = (m == 1 && leap_yr) ? 29 : MONTH_LEN[m];
         if (day_count < len) begin
            break;
         end
         day_count = day_count - len;
         mon++;
      end
      d.valid_res    = 1'b1;
      d.year         = yr[YEAR_W-1:0];
      d.month        = mon[MONTH_W-1:0];
      d.day_of_month = 5'(day_count + 1);
      d.hour         = 5'(tod / SECS_PER_HOUR);
      d.minute       = 6'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
      d.second       = 6'(tod % SECS_PER_MIN);
      return d;
   endfunction

   function automatic logic [EPOCH_W-1:0] random_epoch();
      longint unsigned day;
      longint unsigned tod;
      day = $urandom_range(0, LAST_SAFE_DAY);
      case ($urandom_range(0, 9))
         0: begin
            return $urandom_range(0, BASE_OFFSET - 1);
         end
         1, 2: begin
            tod = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(86397, 86399);
            return 32'(BASE_OFFSET + day * SECS_PER_DAY + tod);
         end
         3, 4: begin
            tod = $urandom_range(0, SECS_PER_DAY - 1);
            return 32'(BASE_OFFSET + day * SECS_PER_DAY + tod);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   function automatic bit busy_phase();
      return !calm_tail && ((req_beats / 64) % 2 == 0);
   endfunction

   task automatic send_epoch(input logic [EPOCH_W-1:0] epoch, input calendar_type want);
      int gap;
      if (busy_phase() && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.epoch_seconds <= epoch;
      do @(posedge clock); while (!req_ch.ready);
      pending_dates.push_back('{epoch, want});
      req_beats++;
      if (epoch < BASE_OFFSET) begin
         early_epochs++;
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int           hold_left;
      bit           long_hold_done;
      pending_type  want;
      calendar_type got;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_ch.ready  <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.valid_res, rsp_ch.year, rsp_ch.month, rsp_ch.day_of_month,
                    rsp_ch.hour, rsp_ch.minute, rsp_ch.second};
            rsp_beats++;
            if (pending_dates.size() == 0) begin
               if (bad_beats < 10) begin
                  $display("unexpected result beat: %p", got);
               end
               bad_beats++;
            end else begin
               want = pending_dates.pop_front();
               if (got.valid_res !== want.date.valid_res || got.year !== want.date.year ||
                   got.month !== want.date.month ||
                   got.day_of_month !== want.date.day_of_month ||
                   got.hour !== want.date.hour || got.minute !== want.date.minute ||
                   got.second !== want.date.second) begin
                  if (bad_beats < 10) begin
                     $display("mismatch for epoch %0d: expected %p, got %p",
                              want.epoch, want.date, got);
                  end
                  bad_beats++;
               end
            end
         end
         if (!long_hold_done && req_beats >= 40) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left == 0 && busy_phase() && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 16);
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [EPOCH_W-1:0] epoch;
      req_beats            = 0;
      rsp_beats            = 0;
      early_epochs         = 0;
      bad_beats            = 0;
      calm_tail            = 1'b0;
      reset               <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.epoch_seconds <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) begin
         send_epoch(probes[i].epoch,
                    probes[i].typed ? probes[i].date : predict_date(probes[i].epoch));
      end

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         calm_tail = (i >= RANDOM_BEATS - CALM_BEATS);
         epoch     = random_epoch();
         send_epoch(epoch, predict_date(epoch));
      end
      req_ch.valid <= 1'b0;

      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d epochs (%0d before 1972), %0d result beats checked, %0d bad",
               req_beats, early_epochs, rsp_beats, bad_beats);
      $display("covered leap days, year and four-year edges, 2100 and the 32-bit extremes");
      if (bad_beats == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
